// ===== src/lslf_pkg.sv =====
// Types and constants shared by the least-squares line fit block.
// No dependencies.
package lslf_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int COUNT_W          = 17;
   localparam int SUM_W            = 33;
   localparam int SXX_W            = 47;
   localparam int SXY_W            = 48;
   localparam int OPND_W           = 48;
   localparam int CHUNK_W          = 24;
   localparam int PROD_W           = 2 * CHUNK_W;
   localparam int ACC_W            = 80;
   localparam int NUM_W            = ACC_W - 1;
   localparam int DEN_W            = 62;
   localparam int QUO_W            = 50;
   localparam int RES_W            = 48;
   localparam int QUO_EXTRA_BITS   = 17;
   localparam int DIV_STEPS        = NUM_W + QUO_EXTRA_BITS;
   localparam int DIV_CNT_W        = $clog2(DIV_STEPS);
   localparam int MAX_SAMPLES_DEF  = 65536;
   localparam int SAMPLE_WIDTH_DEF = 16;

   localparam logic [RES_W-1:0] POS_LIMIT = {1'b0, {(RES_W-1){1'b1}}};
   localparam logic [RES_W-1:0] NEG_LIMIT = {1'b1, {(RES_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_XY,
      ST_PAIR_ACC,
      ST_OP_LOAD,
      ST_MUL,
      ST_ADD,
      ST_D_CHECK,
      ST_DIV_LOAD,
      ST_DIV,
      ST_DIV_END,
      ST_DONE
   } lslf_state_type;

   // cross products, in evaluation order; odd ones are subtracted
   typedef enum logic [2:0] {
      PR_N_SXX,
      PR_SX_SX,
      PR_N_SXY,
      PR_SX_SY,
      PR_SXX_SY,
      PR_SX_SXY
   } lslf_prod_type;

endpackage

// ===== src/least_squares_line_fit.sv =====
// Least-squares line fit over (x, y) pairs; uses lslf_pkg.
// A pair without the last mark holds req_stall through ST_SQ, ST_XY and ST_PAIR_ACC, so the block takes
// no new pair until it is through with the last one (one shared 24x24 multiplier). After the last pair, six
// chunked cross products run on that multiplier and adder, and two 96-step restoring divisions follow.
// Reset (synchronous, active high) clears the sequencer, all sums and the response valid flag.
module least_squares_line_fit #(
   parameter int MAX_SAMPLES  = lslf_pkg::MAX_SAMPLES_DEF,
   parameter int SAMPLE_WIDTH = lslf_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [lslf_pkg::SAMPLE_W-1:0]   req_x_value,
   input  logic signed [lslf_pkg::SAMPLE_W-1:0]   req_y_value,
   input  logic                                   req_last_pair,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lslf_pkg::RES_W-1:0]      rsp_slope,
   output logic signed [lslf_pkg::RES_W-1:0]      rsp_intercept,
   output logic                                   rsp_fit_valid,
   output logic [lslf_pkg::COUNT_W-1:0]           rsp_pair_count
);

   localparam int SEXT_SH = lslf_pkg::SAMPLE_W - SAMPLE_WIDTH;

   lslf_pkg::lslf_state_type state_ff, state_in;
   lslf_pkg::lslf_prod_type  prod_ff, prod_in;

   logic [lslf_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [lslf_pkg::SUM_W-1:0]     sx_ff, sx_in, sy_ff, sy_in;
   logic [lslf_pkg::SXX_W-1:0]     sxx_ff, sxx_in;
   logic [lslf_pkg::SXY_W-1:0]     sxy_ff, sxy_in;
   logic                           last_ff, last_in;
   logic [lslf_pkg::SAMPLE_W-1:0]  x_mag_ff, x_mag_in, y_mag_ff, y_mag_in;
   logic                           xy_neg_ff, xy_neg_in;

   logic [1:0]                     part_ff, part_in;
   logic [lslf_pkg::OPND_W-1:0]    opa_ff, opa_in, opb_ff, opb_in;
   logic                           neg_ff, neg_in;
   logic [lslf_pkg::PROD_W-1:0]    pp_ff, pp_in;
   logic [1:0]                     pp_sh_ff, pp_sh_in;
   logic [lslf_pkg::ACC_W-1:0]     acc_ff, acc_in;

   logic [lslf_pkg::DEN_W-1:0]     den_ff, den_in, rem_ff, rem_in;
   logic [lslf_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [lslf_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic                           sat_ff, sat_in, div_neg_ff, div_neg_in;
   logic [lslf_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic [lslf_pkg::RES_W-1:0]     slope_ff, slope_in, icpt_ff, icpt_in;
   logic                           fitv_ff, fitv_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lslf_pkg::RES_W-1:0]     rsp_slope_ff, rsp_slope_in, rsp_icpt_ff, rsp_icpt_in;
   logic                           rsp_fitv_ff, rsp_fitv_in;
   logic [lslf_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                           req_xfer, rsp_free;
   logic signed [lslf_pkg::SAMPLE_W-1:0] x_sh, y_sh, x_s, y_s;
   logic [lslf_pkg::COUNT_W-1:0]   count_inc;
   logic signed [lslf_pkg::OPND_W:0] opa_s, opb_s;
   logic [lslf_pkg::CHUNK_W-1:0]   mul_a, mul_b;
   logic [lslf_pkg::PROD_W-1:0]    mul_p;
   logic [lslf_pkg::ACC_W-1:0]     pp_ext;
   logic [lslf_pkg::DEN_W:0]       rem_sh;
   logic                           rem_ge;
   logic [lslf_pkg::QUO_W:0]       quo_sh;
   logic [lslf_pkg::QUO_W-1:0]     quo_rnd;
   logic [lslf_pkg::RES_W-1:0]     div_res;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != lslf_pkg::ST_IDLE);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slope      = rsp_slope_ff;
   assign rsp_intercept  = rsp_icpt_ff;
   assign rsp_fit_valid  = rsp_fitv_ff;
   assign rsp_pair_count = rsp_count_ff;

   // sample sign extension from SAMPLE_WIDTH bits
   assign x_sh      = req_x_value <<< SEXT_SH;
   assign y_sh      = req_y_value <<< SEXT_SH;
   assign x_s       = x_sh >>> SEXT_SH;
   assign y_s       = y_sh >>> SEXT_SH;
   assign count_inc = count_ff + 1'b1;

   // cross product operands
   always_comb begin
      case (prod_ff)
         lslf_pkg::PR_N_SXX: begin
            opa_s = {32'd0, count_ff};
            opb_s = {2'd0, sxx_ff};
         end
         lslf_pkg::PR_SX_SX: begin
            opa_s = {{16{sx_ff[32]}}, sx_ff};
            opb_s = {{16{sx_ff[32]}}, sx_ff};
         end
         lslf_pkg::PR_N_SXY: begin
            opa_s = {32'd0, count_ff};
            opb_s = {sxy_ff[47], sxy_ff};
         end
         lslf_pkg::PR_SX_SY: begin
            opa_s = {{16{sx_ff[32]}}, sx_ff};
            opb_s = {{16{sy_ff[32]}}, sy_ff};
         end
         lslf_pkg::PR_SXX_SY: begin
            opa_s = {2'd0, sxx_ff};
            opb_s = {{16{sy_ff[32]}}, sy_ff};
         end
         lslf_pkg::PR_SX_SXY: begin
            opa_s = {{16{sx_ff[32]}}, sx_ff};
            opb_s = {sxy_ff[47], sxy_ff};
         end
         default: begin
            opa_s = '0;
            opb_s = '0;
         end
      endcase
   end

   // shared multiplier
   always_comb begin
      case (state_ff)
         lslf_pkg::ST_SQ: begin
            mul_a = {8'd0, x_mag_ff};
            mul_b = {8'd0, x_mag_ff};
         end
         lslf_pkg::ST_XY: begin
            mul_a = {8'd0, x_mag_ff};
            mul_b = {8'd0, y_mag_ff};
         end
         default: begin
            mul_a = part_ff[1] ? opa_ff[47:24] : opa_ff[23:0];
            mul_b = part_ff[0] ? opb_ff[47:24] : opb_ff[23:0];
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   always_comb begin
      case (pp_sh_ff)
         2'd0:    pp_ext = lslf_pkg::ACC_W'(pp_ff);
         2'd1:    pp_ext = lslf_pkg::ACC_W'({pp_ff, 24'd0});
         default: pp_ext = lslf_pkg::ACC_W'({pp_ff, 48'd0});
      endcase
   end

   // restoring division step and final rounding
   assign rem_sh  = {rem_ff, num_ff[lslf_pkg::NUM_W-1]};
   assign rem_ge  = (rem_sh >= {1'b0, den_ff});
   assign quo_sh  = {quo_ff, rem_ge};
   assign quo_rnd = lslf_pkg::QUO_W'(({1'b0, quo_ff} + 1'b1) >> 1);

   always_comb begin
      if (!div_neg_ff) begin
         if (sat_ff || quo_rnd > lslf_pkg::QUO_W'(lslf_pkg::POS_LIMIT)) begin
            div_res = lslf_pkg::POS_LIMIT;
         end else begin
            div_res = quo_rnd[lslf_pkg::RES_W-1:0];
         end
      end else begin
         if (sat_ff || quo_rnd > lslf_pkg::QUO_W'(lslf_pkg::NEG_LIMIT)) begin
            div_res = lslf_pkg::NEG_LIMIT;
         end else begin
            div_res = lslf_pkg::RES_W'(-quo_rnd);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lslf_pkg::ST_IDLE:     if (req_xfer) state_in = lslf_pkg::ST_SQ;
         lslf_pkg::ST_SQ:       state_in = lslf_pkg::ST_XY;
         lslf_pkg::ST_XY:       state_in = lslf_pkg::ST_PAIR_ACC;
         lslf_pkg::ST_PAIR_ACC: state_in = last_ff ? lslf_pkg::ST_OP_LOAD : lslf_pkg::ST_IDLE;
         lslf_pkg::ST_OP_LOAD:  state_in = lslf_pkg::ST_MUL;
         lslf_pkg::ST_MUL:      state_in = lslf_pkg::ST_ADD;
         lslf_pkg::ST_ADD: begin
            if (part_ff != 2'd3) begin
               state_in = lslf_pkg::ST_MUL;
            end else if (!prod_ff[0]) begin
               state_in = lslf_pkg::ST_OP_LOAD;
            end else if (prod_ff == lslf_pkg::PR_SX_SX) begin
               state_in = lslf_pkg::ST_D_CHECK;
            end else begin
               state_in = lslf_pkg::ST_DIV_LOAD;
            end
         end
         lslf_pkg::ST_D_CHECK:
            state_in = (acc_ff == '0) ? lslf_pkg::ST_DONE : lslf_pkg::ST_OP_LOAD;
         lslf_pkg::ST_DIV_LOAD: state_in = lslf_pkg::ST_DIV;
         lslf_pkg::ST_DIV: begin
            if (div_cnt_ff == lslf_pkg::DIV_CNT_W'(lslf_pkg::DIV_STEPS - 1)) begin
               state_in = lslf_pkg::ST_DIV_END;
            end
         end
         lslf_pkg::ST_DIV_END:
            state_in = (prod_ff == lslf_pkg::PR_SX_SXY) ? lslf_pkg::ST_DONE
                                                        : lslf_pkg::ST_OP_LOAD;
         lslf_pkg::ST_DONE:     if (rsp_free) state_in = lslf_pkg::ST_IDLE;
         default:               state_in = lslf_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in     = count_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sxx_in       = sxx_ff;
      sxy_in       = sxy_ff;
      last_in      = last_ff;
      x_mag_in     = x_mag_ff;
      y_mag_in     = y_mag_ff;
      xy_neg_in    = xy_neg_ff;
      prod_in      = prod_ff;
      part_in      = part_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      neg_in       = neg_ff;
      pp_in        = pp_ff;
      pp_sh_in     = pp_sh_ff;
      acc_in       = acc_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      sat_in       = sat_ff;
      div_neg_in   = div_neg_ff;
      div_cnt_in   = div_cnt_ff;
      slope_in     = slope_ff;
      icpt_in      = icpt_ff;
      fitv_in      = fitv_ff;
      rsp_slope_in = rsp_slope_ff;
      rsp_icpt_in  = rsp_icpt_ff;
      rsp_fitv_in  = rsp_fitv_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         lslf_pkg::ST_IDLE: begin
            if (req_xfer) begin
               count_in  = count_inc;
               sx_in     = sx_ff + {{17{x_s[15]}}, x_s};
               sy_in     = sy_ff + {{17{y_s[15]}}, y_s};
               x_mag_in  = x_s[15] ? lslf_pkg::SAMPLE_W'(-x_s) : x_s;
               y_mag_in  = y_s[15] ? lslf_pkg::SAMPLE_W'(-y_s) : y_s;
               xy_neg_in = x_s[15] ^ y_s[15];
               last_in   = req_last_pair ||
                           (count_inc >= lslf_pkg::COUNT_W'(MAX_SAMPLES));
            end
         end
         lslf_pkg::ST_SQ: begin
            pp_in = mul_p;
         end
         lslf_pkg::ST_XY: begin
            sxx_in = sxx_ff + pp_ff[lslf_pkg::SXX_W-1:0];
            pp_in  = mul_p;
         end
         lslf_pkg::ST_PAIR_ACC: begin
            sxy_in  = xy_neg_ff ? sxy_ff - pp_ff : sxy_ff + pp_ff;
            prod_in = lslf_pkg::PR_N_SXX;
         end
         lslf_pkg::ST_OP_LOAD: begin
            opa_in  = lslf_pkg::OPND_W'(opa_s[48] ? -opa_s : opa_s);
            opb_in  = lslf_pkg::OPND_W'(opb_s[48] ? -opb_s : opb_s);
            neg_in  = opa_s[48] ^ opb_s[48] ^ prod_ff[0];
            part_in = 2'd0;
            if (!prod_ff[0]) begin
               acc_in = '0;
            end
         end
         lslf_pkg::ST_MUL: begin
            pp_in    = mul_p;
            pp_sh_in = {1'b0, part_ff[1]} + {1'b0, part_ff[0]};
         end
         lslf_pkg::ST_ADD: begin
            acc_in  = neg_ff ? acc_ff - pp_ext : acc_ff + pp_ext;
            part_in = part_ff + 1'b1;
            if (part_ff == 2'd3 && !prod_ff[0]) begin
               prod_in = lslf_pkg::lslf_prod_type'(prod_ff + 1'b1);
            end
         end
         lslf_pkg::ST_D_CHECK: begin
            den_in = acc_ff[lslf_pkg::DEN_W-1:0];
            if (acc_ff == '0) begin
               slope_in = '0;
               icpt_in  = '0;
               fitv_in  = 1'b0;
            end else begin
               fitv_in = 1'b1;
               prod_in = lslf_pkg::lslf_prod_type'(prod_ff + 1'b1);
            end
         end
         lslf_pkg::ST_DIV_LOAD: begin
            div_neg_in = acc_ff[lslf_pkg::ACC_W-1];
            num_in     = acc_ff[lslf_pkg::ACC_W-1] ? lslf_pkg::NUM_W'(-acc_ff)
                                                   : acc_ff[lslf_pkg::NUM_W-1:0];
            rem_in     = '0;
            quo_in     = '0;
            sat_in     = 1'b0;
            div_cnt_in = '0;
         end
         lslf_pkg::ST_DIV: begin
            rem_in     = rem_ge ? lslf_pkg::DEN_W'(rem_sh - {1'b0, den_ff})
                                : rem_sh[lslf_pkg::DEN_W-1:0];
            quo_in     = quo_sh[lslf_pkg::QUO_W-1:0];
            sat_in     = sat_ff || quo_sh[lslf_pkg::QUO_W];
            num_in     = {num_ff[lslf_pkg::NUM_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + 1'b1;
         end
         lslf_pkg::ST_DIV_END: begin
            if (prod_ff == lslf_pkg::PR_SX_SY) begin
               slope_in = div_res;
               prod_in  = lslf_pkg::lslf_prod_type'(prod_ff + 1'b1);
            end else begin
               icpt_in = div_res;
            end
         end
         lslf_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_slope_in = slope_ff;
               rsp_icpt_in  = icpt_ff;
               rsp_fitv_in  = fitv_ff;
               rsp_count_in = count_ff;
               count_in     = '0;
               sx_in        = '0;
               sy_in        = '0;
               sxx_in       = '0;
               sxy_in       = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lslf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxx_ff       <= '0;
         sxy_ff       <= '0;
         last_ff      <= 1'b0;
         prod_ff      <= lslf_pkg::PR_N_SXX;
         part_ff      <= '0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sxx_ff       <= sxx_in;
         sxy_ff       <= sxy_in;
         last_ff      <= last_in;
         prod_ff      <= prod_in;
         part_ff      <= part_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_mag_ff     <= x_mag_in;
      y_mag_ff     <= y_mag_in;
      xy_neg_ff    <= xy_neg_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      neg_ff       <= neg_in;
      pp_ff        <= pp_in;
      pp_sh_ff     <= pp_sh_in;
      acc_ff       <= acc_in;
      den_ff       <= den_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      sat_ff       <= sat_in;
      div_neg_ff   <= div_neg_in;
      slope_ff     <= slope_in;
      icpt_ff      <= icpt_in;
      fitv_ff      <= fitv_in;
      rsp_slope_ff <= rsp_slope_in;
      rsp_icpt_ff  <= rsp_icpt_in;
      rsp_fitv_ff  <= rsp_fitv_in;
      rsp_count_ff <= rsp_count_in;
   end

`ifndef NO_ASSERTIONS
   a_div_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lslf_pkg::ST_DIV) |-> (den_ff != '0))
      else $error("division started with zero denominator");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lslf_pkg::ST_DIV) |-> (rem_ff < den_ff))
      else $error("partial remainder not below denominator");

   a_undef_fit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fit_valid) |-> (rsp_slope == '0 && rsp_intercept == '0))
      else $error("undefined fit carries nonzero slope or intercept");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pair_count != '0))
      else $error("result transfer with zero pair count");
`endif

endmodule
